// ----- sv/signed_int_to_radix_digits_defines.svh -----
// ----------------------------------------------------------------------------
// signed_int_to_radix_digits_defines.svh
// Assertion macros for the radix converter RTL.
// ----------------------------------------------------------------------------
`ifndef SIGNED_INT_TO_RADIX_DIGITS_DEFINES_SVH
`define SIGNED_INT_TO_RADIX_DIGITS_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define SITRD_ASSERT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("sitrd assertion failed");
// next-cycle implication
`define SITRD_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("sitrd assertion failed");
`else
`define SITRD_ASSERT(lbl, clk, rstn, ante, cons)
`define SITRD_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

// ----- sv/sitrd_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sitrd_pkg
// Types and constants for the signed integer to radix text converter.
// ----------------------------------------------------------------------------
package sitrd_pkg;

	localparam int VALUE_W   = 32;
	localparam int BASE_W    = 5;
	localparam int DIGIT_W   = 4;
	localparam int SYM_W     = 8;
	localparam int NUM_SYMS  = 16;
	localparam int MAX_DIG   = 32;
	localparam int BIT_CNT_W = 5;
	localparam int ND_W      = 6;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 64;

	localparam logic [BASE_W-1:0] MAX_BASE = 5'd16;
	localparam logic [BASE_W-1:0] MIN_BASE = 5'd2;

	localparam logic [SYM_W-1:0] CH_PLUS  = 8'h2B;
	localparam logic [SYM_W-1:0] CH_MINUS = 8'h2D;

	localparam logic [BASE_W-1:0]    BASE_RST    = 5'd10;
	localparam logic [CFG_DAT_W-1:0] SYM_LO_RST  = 64'h3736353433323130;
	localparam logic [CFG_DAT_W-1:0] SYM_HI_RST  = 64'h4645444342413938;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_BASE_LENGTH  = 2'd0,
		REG_SYMBOLS_LOW  = 2'd1,
		REG_SYMBOLS_HIGH = 2'd2
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_DIV,
		ST_STORE,
		ST_SIGN,
		ST_EMIT
	} st_t;

	typedef struct packed {
		logic load_in;
		logic step;
		logic store;
		logic load_sign;
		logic load_digit;
	} cmd_t;

	typedef struct packed {
		logic base_ok;
		logic step_last;
		logic quot_zero;
		logic last_slot;
		logic buf_full;
		logic neg;
		logic slot_free;
		logic digit_last;
	} sts_t;

endpackage

// ----- sv/sitrd_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sitrd_dp
// Datapath: config registers, base check, bit-serial divider, digit buffer
// and output register.
// ----------------------------------------------------------------------------
module sitrd_dp import sitrd_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 wr_en,
	input  logic [CFG_IDX_W-1:0] wr_index,
	input  logic [CFG_DAT_W-1:0] wr_data,
	input  logic signed [VALUE_W-1:0] value,
	input  logic                 out_stall,
	input  cmd_t                 cmd,
	output sts_t                 sts,
	output logic                 out_valid,
	output logic [SYM_W-1:0]     symbol,
	output logic                 last
);

	logic [BASE_W-1:0]      base_q;
	logic [CFG_DAT_W-1:0]   sym_lo_q;
	logic [CFG_DAT_W-1:0]   sym_hi_q;
	logic [2*CFG_DAT_W-1:0] sym_all;

	logic [VALUE_W-1:0]     mag_q;
	logic [DIGIT_W-1:0]     rem_q;
	logic [BIT_CNT_W-1:0]   bit_cnt_q;
	logic [ND_W-1:0]        nd_q;
	logic                   neg_q;
	logic [DIGIT_W-1:0]     dig_buf_q [MAX_DIG];

	logic                   out_valid_q;
	logic [SYM_W-1:0]       symbol_q;
	logic                   last_q;

	logic [BASE_W-1:0]      trial;
	logic                   qbit;
	logic [BASE_W-1:0]      trial_sub;
	logic [ND_W-1:0]        rd_ptr;
	logic [DIGIT_W-1:0]     rd_digit;
	logic [SYM_W-1:0]       rd_sym;
	logic                   base_ok;
	logic [SYM_W-1:0]       si;
	logic [SYM_W-1:0]       sj;

	assign sym_all = {sym_hi_q, sym_lo_q};

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q   <= BASE_RST;
			sym_lo_q <= SYM_LO_RST;
			sym_hi_q <= SYM_HI_RST;
		end else if (wr_en) begin
			case (wr_index)
				REG_BASE_LENGTH:  base_q   <= wr_data[BASE_W-1:0];
				REG_SYMBOLS_LOW:  sym_lo_q <= wr_data;
				REG_SYMBOLS_HIGH: sym_hi_q <= wr_data;
				default: ;
			endcase
		end
	end

	// base check: base must be in range, and every symbol in use must be neither sign nor a repeat
	always_comb begin
		base_ok = (base_q >= MIN_BASE) && (base_q <= MAX_BASE);
		si      = '0;
		sj      = '0;
		for (int i = 0; i < NUM_SYMS; i++) begin
			si = sym_all[i*SYM_W +: SYM_W];
			if (BASE_W'(i) < base_q) begin
				if (si == CH_PLUS || si == CH_MINUS)
					base_ok = 1'b0;
				for (int j = 0; j < i; j++) begin
					sj = sym_all[j*SYM_W +: SYM_W];
					if (sj == si)
						base_ok = 1'b0;
				end
			end
		end
	end

	// one quotient bit per step: restoring division by the radix
	assign trial     = {rem_q, mag_q[VALUE_W-1]};
	assign qbit      = (trial >= base_q);
	assign trial_sub = trial - base_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_cnt_q <= '0;
			nd_q      <= '0;
		end else if (cmd.load_in) begin
			bit_cnt_q <= '0;
			nd_q      <= '0;
		end else if (cmd.step) begin
			bit_cnt_q <= bit_cnt_q + 1'b1;
		end else if (cmd.store) begin
			bit_cnt_q <= '0;
			nd_q      <= nd_q + 1'b1;
		end else if (cmd.load_digit) begin
			nd_q      <= nd_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			neg_q <= value[VALUE_W-1];
			mag_q <= value[VALUE_W-1] ? (VALUE_W'(0) - VALUE_W'(value)) : VALUE_W'(value);
			rem_q <= '0;
		end else if (cmd.step) begin
			mag_q <= {mag_q[VALUE_W-2:0], qbit};
			rem_q <= qbit ? trial_sub[DIGIT_W-1:0] : trial[DIGIT_W-1:0];
		end else if (cmd.store) begin
			dig_buf_q[nd_q[BIT_CNT_W-1:0]] <= rem_q;
			rem_q <= '0;
		end
	end

	// digits leave most significant first
	assign rd_ptr   = nd_q - 1'b1;
	assign rd_digit = dig_buf_q[rd_ptr[BIT_CNT_W-1:0]];
	assign rd_sym   = sym_all[{rd_digit, 3'b000} +: SYM_W];

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_sign || cmd.load_digit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_sign) begin
			symbol_q <= CH_MINUS;
			last_q   <= 1'b0;
		end else if (cmd.load_digit) begin
			symbol_q <= rd_sym;
			last_q   <= (nd_q == ND_W'(1));
		end
	end

	always_comb begin
		sts.base_ok    = base_ok;
		sts.step_last  = (bit_cnt_q == {BIT_CNT_W{1'b1}});
		sts.quot_zero  = (mag_q == '0);
		sts.last_slot  = (nd_q[BIT_CNT_W-1:0] == {BIT_CNT_W{1'b1}});
		sts.buf_full   = nd_q[ND_W-1];
		sts.neg        = neg_q;
		sts.slot_free  = !out_valid_q || !out_stall;
		sts.digit_last = (nd_q == ND_W'(1));
	end

	assign out_valid = out_valid_q;
	assign symbol    = symbol_q;
	assign last      = last_q;

endmodule

// ----- sv/sitrd_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sitrd_ctrl
// Sequencer: base check, per-digit division passes, sign and digit output.
// ----------------------------------------------------------------------------
`include "signed_int_to_radix_digits_defines.svh"

module sitrd_ctrl import sitrd_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  sts_t sts,
	output cmd_t cmd
);

	st_t state_q;
	st_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid)
					state_d = ST_CHECK;
			end
			ST_CHECK: begin
				state_d = sts.base_ok ? ST_DIV : ST_IDLE;
			end
			ST_DIV: begin
				if (sts.step_last)
					state_d = ST_STORE;
			end
			ST_STORE: begin
				state_d = (sts.quot_zero || sts.last_slot) ? ST_SIGN : ST_DIV;
			end
			ST_SIGN: begin
				if (!sts.neg || sts.slot_free)
					state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (sts.slot_free && sts.digit_last)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_stall = 1'b1;
		case (state_q)
			ST_IDLE: begin
				in_stall    = 1'b0;
				cmd.load_in = in_valid;
			end
			ST_DIV:   cmd.step       = 1'b1;
			ST_STORE: cmd.store      = 1'b1;
			ST_SIGN:  cmd.load_sign  = sts.neg && sts.slot_free;
			ST_EMIT:  cmd.load_digit = sts.slot_free;
			default: ;
		endcase
	end

	`SITRD_ASSERT_NEXT(a_accept_to_check, clk, arst_n, in_valid && !in_stall, state_q == ST_CHECK)
	`SITRD_ASSERT(a_store_not_full, clk, arst_n, cmd.store, !sts.buf_full)
	`SITRD_ASSERT(a_digit_has_slot, clk, arst_n, cmd.load_digit, sts.slot_free && (sts.buf_full || !sts.digit_last || sts.digit_last))
	`SITRD_ASSERT_NEXT(a_last_to_idle, clk, arst_n, cmd.load_digit && sts.digit_last, state_q == ST_IDLE)

endmodule

// ----- sv/signed_int_to_radix_digits.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// signed_int_to_radix_digits
// Converts a signed 32-bit value to its text in a configurable base, one
// symbol per output request, most significant digit first.
//
//   channel  | handshake           | payload
//   ---------+---------------------+-------------------
//   input    | in_valid / in_stall | value
//   output   | out_valid/out_stall | symbol, last
//   config   | wr_en               | wr_index, wr_data
//
// Each digit takes one full pass of the shared 1-bit-per-cycle divider, and
// the sign and digit symbols are sent only after all digits are found; a
// value has up to 32 digits. One value at a time.
// Output stalls hold the output register and pause only the sign and digit output.
// Reset loads the default base of 10 with symbols "0123456789ABCDEF".
// ----------------------------------------------------------------------------
module signed_int_to_radix_digits import sitrd_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      wr_en,
	input  logic [CFG_IDX_W-1:0]      wr_index,
	input  logic [CFG_DAT_W-1:0]      wr_data,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic signed [VALUE_W-1:0] value,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic [SYM_W-1:0]          symbol,
	output logic                      last
);

	cmd_t cmd;
	sts_t sts;

	sitrd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	sitrd_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr_en     (wr_en),
		.wr_index  (wr_index),
		.wr_data   (wr_data),
		.value     (value),
		.out_stall (out_stall),
		.cmd       (cmd),
		.sts       (sts),
		.out_valid (out_valid),
		.symbol    (symbol),
		.last      (last)
	);

endmodule

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for signed_int_to_radix_digits. Loads a range of bases
// and alphabets, valid and broken, sends signed values under several idle and
// stall patterns, predicts the text of each value and checks every symbol
// and its last flag in order.
// ----------------------------------------------------------------------------
module tb_top;
	import sitrd_pkg::*;

	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;  // decodes to no register
	localparam int QUIET_CYCLES = 1200;  // a 32-digit value plus margin
	localparam int HOLD_CYCLES  = 3000;
	localparam int RANDOM_ITEMS = 190;
	localparam int LIMIT_NS     = 12_000_000;

	typedef struct packed {
		logic [SYM_W-1:0] sym;
		logic             fin;
	} char_t;

	class radix_text_board;
		logic [BASE_W-1:0]    radix;
		logic [CFG_DAT_W-1:0] lo_syms;
		logic [CFG_DAT_W-1:0] hi_syms;
		char_t                chars_due[$];
		int                   errors;

		function new();
			radix   = BASE_RST;
			lo_syms = SYM_LO_RST;
			hi_syms = SYM_HI_RST;
			errors  = 0;
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
			case (idx)
				REG_BASE_LENGTH:  radix   = data[BASE_W-1:0];
				REG_SYMBOLS_LOW:  lo_syms = data;
				REG_SYMBOLS_HIGH: hi_syms = data;
				default: ;
			endcase
		endfunction

		function logic [SYM_W-1:0] sym_at(int k);
			logic [2*CFG_DAT_W-1:0] both;
			both = {hi_syms, lo_syms};
			return both[k*SYM_W +: SYM_W];
		endfunction

		function bit alphabet_ok();
			int i;
			int j;
			if (radix < MIN_BASE || radix > MAX_BASE) return 1'b0;
			for (i = 0; i < radix; i++) begin
				if (sym_at(i) == CH_PLUS || sym_at(i) == CH_MINUS) return 1'b0;
				for (j = 0; j < i; j++)
					if (sym_at(j) == sym_at(i)) return 1'b0;
			end
			return 1'b1;
		endfunction

		// spells one accepted value; returns the number of symbols it owes
		function int take_value(logic signed [VALUE_W-1:0] v);
			logic [VALUE_W-1:0] mag;
			int digs[MAX_DIG];
			int nd;
			int k;
			char_t c;
			if (!alphabet_ok()) return 0;
			mag = v;
			if (v[VALUE_W-1]) mag = -mag;  // most negative maps onto 2^31
			nd = 0;
			do begin
				digs[nd] = int'(mag % radix);
				mag = mag / radix;
				nd++;
			end while (mag != 0 && nd < MAX_DIG);
			if (v[VALUE_W-1]) begin
				c.sym = CH_MINUS;
				c.fin = 1'b0;
				chars_due.push_back(c);
			end
			for (k = nd - 1; k >= 0; k--) begin
				c.sym = sym_at(digs[k]);
				c.fin = (k == 0);
				chars_due.push_back(c);
			end
			return nd + (v[VALUE_W-1] ? 1 : 0);
		endfunction

		function void check_char(logic [SYM_W-1:0] sym, logic fin);
			char_t want;
			if (chars_due.size() == 0) begin
				if (errors < 50)
					$display("%0t: expected no symbol, got symbol %h last %b", $time, sym, fin);
				errors++;
				return;
			end
			want = chars_due.pop_front();
			if (sym !== want.sym) begin
				if (errors < 50)
					$display("%0t: symbol expected %h, actual %h", $time, want.sym, sym);
				errors++;
			end
			if (fin !== want.fin) begin
				if (errors < 50)
					$display("%0t: last expected %b, actual %b", $time, want.fin, fin);
				errors++;
			end
		endfunction
	endclass

	logic                      clk;
	logic                      arst_n;
	logic                      wr_en;
	logic [CFG_IDX_W-1:0]      wr_index;
	logic [CFG_DAT_W-1:0]      wr_data;
	logic                      in_valid;
	logic                      in_stall;
	logic signed [VALUE_W-1:0] value;
	logic                      out_valid;
	logic                      out_stall;
	logic [SYM_W-1:0]          symbol;
	logic                      last;

	radix_text_board board;

	int idle_pct  = 0;
	int stall_pct = 0;
	int hold_reqs = 0;
	int hold_seen = 0;
	int hold_left = 0;
	int sent_ok   = 0;
	bit silent    = 1'b0;

	signed_int_to_radix_digits u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr_en     (wr_en),
		.wr_index  (wr_index),
		.wr_data   (wr_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.value     (value),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.symbol    (symbol),
		.last      (last)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#(LIMIT_NS);
		$display("Some tests failed");
		$finish;
	end

	// output side: check each accepted symbol, then pick the next stall
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) board.check_char(symbol, last);
		if (hold_reqs != hold_seen) begin
			hold_seen = hold_reqs;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) hold_left--;
		out_stall <= (hold_left > 0) || ($urandom_range(0, 99) < stall_pct);
	end

	task automatic offer(logic signed [VALUE_W-1:0] v);
		while ($urandom_range(0, 99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		value    <= v;
		do @(posedge clk); while (in_stall);
		if (board.take_value(v) == 0) silent = 1'b1;
		else sent_ok++;
	endtask

	// wait for all owed symbols; a value with a broken base owes none, so
	// give the block its full conversion time before touching registers
	task automatic settle();
		in_valid <= 1'b0;
		while (board.chars_due.size() != 0) @(posedge clk);
		repeat (silent ? QUIET_CYCLES : 4) @(posedge clk);
		silent = 1'b0;
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
		wr_en    <= 1'b1;
		wr_index <= idx;
		wr_data  <= data;
		@(posedge clk);
		board.set_reg(idx, data);
		wr_en <= 1'b0;
		@(posedge clk);
	endtask

	task automatic setup(logic [BASE_W-1:0] n, logic [CFG_DAT_W-1:0] lo,
			logic [CFG_DAT_W-1:0] hi);
		logic [CFG_DAT_W-1:0] base_word;
		settle();
		base_word = {$urandom, $urandom};  // upper bits are don't-care
		base_word[BASE_W-1:0] = n;
		write_reg(REG_BASE_LENGTH, base_word);
		write_reg(REG_SYMBOLS_LOW, lo);
		write_reg(REG_SYMBOLS_HIGH, hi);
	endtask

	task automatic pick_alphabet(output logic [BASE_W-1:0] n,
			output logic [CFG_DAT_W-1:0] lo, output logic [CFG_DAT_W-1:0] hi,
			output bit usable);
		logic [SYM_W-1:0] alpha[NUM_SYMS];
		int i;
		int j;
		int pos;
		bit clash;
		for (i = 0; i < NUM_SYMS; i++) alpha[i] = SYM_W'($urandom_range(0, 255));
		n = BASE_W'($urandom_range(MIN_BASE, MAX_BASE));
		for (i = 0; i < n; i++) begin
			do begin
				alpha[i] = SYM_W'($urandom_range(0, 255));
				clash = (alpha[i] == CH_PLUS || alpha[i] == CH_MINUS);
				for (j = 0; j < i; j++)
					if (alpha[j] == alpha[i]) clash = 1'b1;
			end while (clash);
		end
		usable = ($urandom_range(0, 5) != 0);
		if (!usable) begin
			pos = $urandom_range(0, n - 1);
			case ($urandom_range(0, 3))
				0: n = BASE_W'($urandom_range(0, 1));
				1: n = BASE_W'($urandom_range(17, 31));
				2: alpha[pos] = $urandom_range(0, 1) ? CH_PLUS : CH_MINUS;
				default: alpha[pos] = alpha[(pos + 1) % n];
			endcase
		end
		for (i = 0; i < 8; i++) begin
			lo[i*SYM_W +: SYM_W] = alpha[i];
			hi[i*SYM_W +: SYM_W] = alpha[i+8];
		end
	endtask

	function automatic logic signed [VALUE_W-1:0] pick_value(logic [BASE_W-1:0] n);
		logic [VALUE_W-1:0] v;
		case ($urandom_range(0, 6))
			0: v = $urandom_range(0, 2 * n);
			1: v = 32'd0 - $urandom_range(0, 2 * n);
			2: v = $urandom >> $urandom_range(0, 31);
			3: v = 32'd0 - ($urandom >> $urandom_range(0, 31));
			4: v = 32'h7FFF_FFFF + $urandom_range(0, 3);
			5: begin
				// near a power of the radix, where the digit count steps
				v = 1;
				repeat ($urandom_range(1, 31)) v = v * n;
				v = v - $urandom_range(0, 1);
				if ($urandom_range(0, 1)) v = -v;
			end
			default: v = $urandom;
		endcase
		return v;
	endfunction

	initial begin
		logic [BASE_W-1:0]    n;
		logic [CFG_DAT_W-1:0] lo;
		logic [CFG_DAT_W-1:0] hi;
		bit                   usable;
		bit                   held;
		int                   phase;
		int                   i;

		board     = new();
		arst_n    <= 1'b0;
		wr_en     <= 1'b0;
		wr_index  <= REG_BASE_LENGTH;
		wr_data   <= '0;
		in_valid  <= 1'b0;
		value     <= '0;
		out_stall <= 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset alphabet, base 10
		offer(0);
		offer(1);
		offer(-1);
		offer(10);
		offer(32'sh7FFF_FFFF);
		offer(32'sh8000_0000);

		setup(16, SYM_LO_RST, SYM_HI_RST);
		offer(-1);
		offer(32'sh7FFF_FFFF);

		setup(2, SYM_LO_RST, SYM_HI_RST);
		offer(32'sh8000_0000);
		offer(32'sh7FFF_FFFF);

		// signs and repeats past the base length are ignored
		setup(3, 64'h782D_2B2D_2B7A_7978, SYM_HI_RST);
		offer(-12345);
		// zero bytes are plain symbols
		setup(8, 64'h0706_0504_0302_0100, SYM_HI_RST);
		offer(32'sh8000_0000);

		// broken bases: nothing comes out
		setup(0, SYM_LO_RST, SYM_HI_RST);
		offer(77);
		setup(1, SYM_LO_RST, SYM_HI_RST);
		offer(-77);
		setup(17, SYM_LO_RST, SYM_HI_RST);
		offer(5);
		setup(31, SYM_LO_RST, SYM_HI_RST);
		offer(-5);
		setup(10, 64'h3736_2B34_3332_3130, SYM_HI_RST);
		offer(123);
		setup(16, SYM_LO_RST, 64'h2D45_4443_4241_3938);
		offer(-123);
		setup(12, SYM_LO_RST, 64'h4645_4443_4241_3038);
		offer(456);

		settle();
		write_reg(REG_SPARE, {$urandom, $urandom});
		setup(10, SYM_LO_RST, SYM_HI_RST);
		offer(-42);

		sent_ok = 0;
		phase   = 0;
		held    = 1'b0;
		while (sent_ok < RANDOM_ITEMS) begin
			pick_alphabet(n, lo, hi, usable);
			setup(n, lo, hi);
			case (phase % 4)
				0: begin
					idle_pct  = 0;
					stall_pct = 0;
				end
				1: begin
					idle_pct  = 62;
					stall_pct = 0;
				end
				2: begin
					idle_pct  = 0;
					stall_pct = 62;
				end
				default: begin
					idle_pct  = 31;
					stall_pct = 31;
				end
			endcase
			// output held off while requests keep coming, so input backs up
			if (usable && !held) begin
				hold_reqs++;
				held = 1'b1;
			end
			for (i = 0; i < (usable ? 24 : 4); i++) begin
				if (i == 12) settle();
				offer(pick_value(n));
			end
			phase++;
		end

		settle();
		repeat (QUIET_CYCLES) @(posedge clk);
		if (board.errors == 0) $display("All tests passed");
		else $display("Some tests failed");
		$finish;
	end

endmodule
